// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the queue modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define APMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define APMQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/apmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apmq_pkg
// types and codes shared by the alarm priority message queue
// ----------------------------------------------------------------------------
package apmq_pkg;

    localparam int WORD_W   = 32;
    localparam int TOTAL_W  = 5;
    localparam int STATUS_W = 3;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    localparam logic KIND_NORMAL = 1'b0;
    localparam logic KIND_ALARM  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_SENT       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_GOT_ALARM  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_GOT_NORMAL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALARM_BUSY = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FIFO_FULL  = 3'd5;

    typedef struct packed {
        logic              operation;
        logic              kind;
        logic [WORD_W-1:0] message;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   message_out;
        logic [TOTAL_W-1:0]  queued_total;
        logic                alarm_pending;
    } t_out;

    // ring control from the top level
    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    // ring occupancy flags back to the top level
    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_sts;

endpackage
`default_nettype wire

// ===== hdl/alarm_priority_message_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// alarm_priority_message_queue
// one alarm slot that takes priority over a ring of normal messages
// ----------------------------------------------------------------------------
// the result is registered and valid in the cycle after the input transfer
// throughput: one send or receive per cycle unless the output stalls, set by
//   the single result register and one-port ring (one write or read per cycle)
// reset: synchronous, active low; empties the ring and the alarm slot at once,
//   ring contents are left as they are, no clearing pass
module alarm_priority_message_queue #(
    parameter int DEPTH = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  wire  apmq_pkg::t_in i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output apmq_pkg::t_out  o_out_data
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SUM_W = ((CW > apmq_pkg::TOTAL_W) ? CW : apmq_pkg::TOTAL_W) + 1;

    // alarm slot
    logic                            r_alarm_valid;
    logic [apmq_pkg::WORD_W-1:0]     r_alarm_word;
    logic                            n_alarm_valid;
    logic [apmq_pkg::WORD_W-1:0]     n_alarm_word;

    // result register
    logic                            r_out_valid;
    logic [apmq_pkg::STATUS_W-1:0]   r_status;
    logic [apmq_pkg::WORD_W-1:0]     r_msg;
    logic                            r_sel_ring;
    logic [apmq_pkg::TOTAL_W-1:0]    r_total;
    logic                            r_alarm_pend;
    logic [apmq_pkg::STATUS_W-1:0]   n_status;
    logic [apmq_pkg::WORD_W-1:0]     n_msg;
    logic                            n_sel_ring;
    logic [SUM_W-1:0]                n_sum;

    // ring interface
    apmq_pkg::t_ring_ctl             ring_ctl;
    apmq_pkg::t_ring_sts             ring_sts;
    logic [apmq_pkg::WORD_W-1:0]     ring_rdata;
    logic [CW-1:0]                   ring_count_next;

    logic                            in_xfer;

    // result register frees up when its contents transfer out
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    apmq_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ring_ctl),
        .i_wdata      (i_in_data.message),
        .o_rdata      (ring_rdata),
        .o_sts        (ring_sts),
        .o_count_next (ring_count_next)
    );

    // decision for one transfer: a receive tries the alarm slot, then the ring
    always_comb begin
        n_alarm_valid = r_alarm_valid;
        n_alarm_word  = r_alarm_word;
        ring_ctl      = '0;
        n_status      = apmq_pkg::ST_EMPTY;
        n_msg         = '0;
        n_sel_ring    = 1'b0;
        if (in_xfer) begin
            if (i_in_data.operation == apmq_pkg::OP_SEND) begin
                if (i_in_data.kind == apmq_pkg::KIND_ALARM) begin
                    // only one alarm can be held
                    if (r_alarm_valid) begin
                        n_status = apmq_pkg::ST_ALARM_BUSY;
                    end else begin
                        n_alarm_valid = 1'b1;
                        n_alarm_word  = i_in_data.message;
                        n_status      = apmq_pkg::ST_SENT;
                    end
                end else if (ring_sts.full) begin
                    n_status = apmq_pkg::ST_FIFO_FULL;
                end else begin
                    ring_ctl.push = 1'b1;
                    n_status      = apmq_pkg::ST_SENT;
                end
            end else begin
                priority if (r_alarm_valid) begin
                    // alarm overtakes waiting normal messages
                    n_msg         = r_alarm_word;
                    n_alarm_valid = 1'b0;
                    n_status      = apmq_pkg::ST_GOT_ALARM;
                end else if (!ring_sts.empty) begin
                    // word comes from the ring's registered read
                    ring_ctl.pop = 1'b1;
                    n_sel_ring   = 1'b1;
                    n_status     = apmq_pkg::ST_GOT_NORMAL;
                end else begin
                    n_status = apmq_pkg::ST_EMPTY;
                end
            end
        end
    end

    // occupancy after this step, cut to the field width
    assign n_sum = SUM_W'(ring_count_next) + SUM_W'(n_alarm_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_alarm_valid <= n_alarm_valid;
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_alarm_word <= n_alarm_word;
        if (in_xfer) begin
            r_status     <= n_status;
            r_msg        <= n_msg;
            r_sel_ring   <= n_sel_ring;
            r_total      <= n_sum[apmq_pkg::TOTAL_W-1:0];
            r_alarm_pend <= n_alarm_valid;
        end
    end

    // ring read data holds until the next transfer, so the mux stays stable
    always_comb begin
        o_out_data.status        = r_status;
        o_out_data.message_out   = r_sel_ring ? ring_rdata : r_msg;
        o_out_data.queued_total  = r_total;
        o_out_data.alarm_pending = r_alarm_pend;
    end

    assign o_out_valid = r_out_valid;

    `APMQ_ASSERT_NXT(a_alarm_first, i_clk, i_rst_n,
        in_xfer && (i_in_data.operation == apmq_pkg::OP_RECV) && r_alarm_valid,
        r_status == apmq_pkg::ST_GOT_ALARM, "receive with alarm held did not take alarm")
    `APMQ_ASSERT_IMP(a_pend_tracks, i_clk, i_rst_n, r_out_valid,
        r_alarm_pend == r_alarm_valid, "reported alarm flag differs from slot")
    `APMQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_out_ready,
        r_out_valid && $stable(o_out_data), "waiting result changed")

endmodule
`default_nettype wire

// ===== hdl/apmq_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// apmq_ring
// ring buffer of normal messages with head, tail and fill count
// ----------------------------------------------------------------------------
module apmq_ring #(
    parameter int DEPTH = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire  apmq_pkg::t_ring_ctl     i_ctl,
    input  wire  [apmq_pkg::WORD_W-1:0]   i_wdata,
    output logic [apmq_pkg::WORD_W-1:0]   o_rdata,
    output apmq_pkg::t_ring_sts           o_sts,
    output logic [$clog2(DEPTH+1)-1:0]    o_count_next
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [apmq_pkg::WORD_W-1:0] mem [DEPTH];
    logic [apmq_pkg::WORD_W-1:0] r_rd_data;
    logic [AW-1:0]               r_head;
    logic [AW-1:0]               r_tail;
    logic [CW-1:0]               r_count;
    logic [AW-1:0]               n_head;
    logic [AW-1:0]               n_tail;
    logic [CW-1:0]               n_count;

    // wrap after the last slot
    assign n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;

    always_comb begin
        priority if (i_ctl.push) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.push) begin
                r_tail <= n_tail;
            end
            if (i_ctl.pop) begin
                r_head <= n_head;
            end
            r_count <= n_count;
        end
    end

    // storage, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_tail] <= i_wdata;
        end
        if (i_ctl.pop) begin
            r_rd_data <= mem[r_head];
        end
    end

    assign o_rdata      = r_rd_data;
    assign o_sts.empty  = (r_count == '0);
    assign o_sts.full   = (r_count == CW'(DEPTH));
    assign o_count_next = n_count;

    `APMQ_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_ctl.push, !o_sts.full,
        "push into full ring")
    `APMQ_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_ctl.pop,
        !o_sts.empty && !i_ctl.push, "pop from empty ring or pop with push")
    `APMQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH),
        "ring count beyond depth")

endmodule
`default_nettype wire
